/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

/* sv/btc_pkg.sv */
`default_nettype none

package btc_pkg;

    localparam int SAMPLE_X_W = 32;
    localparam int SAMPLE_Y_W = 16;
    localparam int OUT_X_W    = 40;
    localparam int OUT_Y_W    = 18;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 2;

    localparam int X_FRAC_BITS_DEF = 8;

    localparam logic [15:0] Y_MIN_RST    = 16'd0;
    localparam logic [15:0] Y_RANGE_RST  = 16'd65535;
    localparam logic [16:0] FRACTION_RST = 17'd6554;

    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RANGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION = 2'd2;

endpackage

`default_nettype wire

/* sv/btc_if.sv */
`default_nettype none

interface btc_in_if import btc_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic        [SAMPLE_X_W-1:0] sample_x;
    logic signed [SAMPLE_Y_W-1:0] sample_y;
    logic                         start_series;

    modport source (output valid, output sample_x, output sample_y, output start_series,
                     input ready);
    modport sink (input valid, input sample_x, input sample_y, input start_series,
                   output ready);
endinterface

interface btc_out_if import btc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic        [OUT_X_W-1:0] out_x;
    logic signed [OUT_Y_W-1:0] out_y;
    logic                      is_crossing;
    logic                      last_of_item;

    modport source (output valid, output out_x, output out_y, output is_crossing,
                     output last_of_item, input ready);
    modport sink (input valid, input out_x, input out_y, input is_crossing,
                   input last_of_item, output ready);
endinterface

`default_nettype wire

/* sv/below_threshold_clip_with_crossings_top.sv */
// a kept sample passes S_MUL, S_CMP and S_EMIT to reach the output register after its item is accepted,
// a crossing passes S_MUL, S_CMP, S_DIV and S_EMIT; S_EMIT waits while the output register is full
// items do not overlap: a new item is accepted only in S_IDLE, once the last one is done, and a kept
// sample that follows a crossing is emitted from S_EMIT2 after the crossing
// reset: synchronous, active low; clears the sequencer, the previous-sample valid and below flags and
// the output valid flag, and loads the three configuration registers with their defaults
`default_nettype none

`include "assert_macros.svh"

module below_threshold_clip_with_crossings_top import btc_pkg::*; #(
    parameter int X_FRAC_BITS = X_FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_data,
    btc_in_if.sink               i_in,
    btc_out_if.source            o_out
);

    localparam int DXW   = SAMPLE_X_W + X_FRAC_BITS;
    localparam int CNT_W = $clog2(DXW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_DIV,
        S_EMIT,
        S_EMIT2
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_y_min;
    logic [15:0] r_y_range;
    logic [16:0] r_fraction;

    // previous sample
    logic [31:0] r_prev_x;
    logic [15:0] r_prev_y;
    logic        r_prev_valid;
    logic        r_below;

    // item in flight
    logic [31:0] r_x;
    logic [15:0] r_y;
    logic        r_start;
    logic [31:0] r_base_x;
    logic [32:0] r_p;
    logic [17:0] r_lvl;
    logic        r_cross;
    logic        r_kept;

    // divider
    logic [31:0]    r_num;
    logic [31:0]    r_den;
    logic [31:0]    r_rem;
    logic [DXW-1:0] r_quo;
    logic [DXW-1:0] r_dx;
    logic [CNT_W-1:0] r_cnt;

    // output register
    logic               r_out_valid;
    logic [OUT_X_W-1:0] r_out_x;
    logic [OUT_Y_W-1:0] r_out_y;
    logic               r_out_cross;
    logic               r_out_last;

    logic [16:0] c_ydiff;
    logic        c_below;
    logic [16:0] c_dy;
    logic [16:0] c_dy_abs;
    logic [15:0] c_den16;
    logic [16:0] c_ymp;
    logic [35:0] c_num_raw;
    logic [35:0] c_num_adj;
    logic        c_in_seg;
    logic        c_prev_ok;
    logic        c_cross;
    logic        c_kept;
    logic [18:0] c_lvl;

    logic        c_bit;
    logic [33:0] c_r2;
    logic [33:0] c_d1;
    logic [33:0] c_d2;
    logic        c_ge1;
    logic        c_ge2;
    logic [33:0] c_rem_nx;
    logic [1:0]  c_digit;

    logic [55:0] c_cross_x;
    logic [55:0] c_kept_x;
    logic        c_out_free;
    logic        c_emit;

    // level comparison and crossing set-up
    always_comb begin
        c_prev_ok = r_prev_valid && !r_start;
        c_ydiff   = {r_y[15], r_y} - {r_y_min[15], r_y_min};
        c_below   = $signed({c_ydiff[16], c_ydiff, 16'd0}) < $signed({1'b0, r_p});
        c_dy      = {r_y[15], r_y} - {r_prev_y[15], r_prev_y};
        c_dy_abs  = c_dy[16] ? (17'd0 - c_dy) : c_dy;
        c_den16   = c_dy_abs[15:0];
        c_ymp     = {r_y_min[15], r_y_min} - {r_prev_y[15], r_prev_y};
        c_num_raw = {{3{c_ymp[16]}}, c_ymp, 16'd0} + {3'b000, r_p};
        c_num_adj = c_dy[16] ? (36'd0 - c_num_raw) : c_num_raw;
        // crossing only counts when it falls inside the segment
        c_in_seg  = !c_num_adj[35] && (c_num_adj <= {4'd0, c_den16, 16'd0});
        c_cross   = c_prev_ok && (c_below != r_below) && (c_dy != 17'd0)
                    && (r_x > r_prev_x) && c_in_seg;
        c_kept    = c_prev_ok && c_below;
        c_lvl     = {{3{r_y_min[15]}}, r_y_min} + {2'b00, r_p[32:16]};
    end

    // one quotient digit per cycle, remainder kept below the divisor
    always_comb begin
        c_bit    = r_dx[DXW-1];
        c_r2     = {1'b0, r_rem, 1'b0} + (c_bit ? {2'b00, r_num} : 34'd0);
        c_d1     = {2'b00, r_den};
        c_d2     = {1'b0, r_den, 1'b0};
        c_ge2    = c_r2 >= c_d2;
        c_ge1    = c_r2 >= c_d1;
        c_rem_nx = c_ge2 ? (c_r2 - c_d2) : (c_ge1 ? (c_r2 - c_d1) : c_r2);
        c_digit  = c_ge2 ? 2'd2 : {1'b0, c_ge1};
    end

    assign c_cross_x  = (56'(r_base_x) << X_FRAC_BITS) + 56'(r_quo);
    assign c_kept_x   = 56'(r_x) << X_FRAC_BITS;
    assign c_out_free = !r_out_valid || o_out.ready;
    assign c_emit     = ((r_state == S_EMIT) || (r_state == S_EMIT2)) && c_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_min    <= Y_MIN_RST;
            r_y_range  <= Y_RANGE_RST;
            r_fraction <= FRACTION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_Y_MIN:    r_y_min    <= i_cfg_data[15:0];
                CFG_Y_RANGE:  r_y_range  <= i_cfg_data[15:0];
                CFG_FRACTION: r_fraction <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_valid <= 1'b0;
            r_below      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (c_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_x     <= i_in.sample_x;
                        r_y     <= i_in.sample_y;
                        r_start <= i_in.start_series;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p     <= 33'(r_fraction) * 33'(r_y_range);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_cross      <= c_cross;
                    r_kept       <= c_kept;
                    r_lvl        <= c_lvl[17:0];
                    r_base_x     <= r_prev_x;
                    r_num        <= c_num_adj[31:0];
                    r_den        <= {c_den16, 16'd0};
                    r_rem        <= 32'd0;
                    r_quo        <= '0;
                    r_dx         <= DXW'(r_x - r_prev_x) << X_FRAC_BITS;
                    r_cnt        <= CNT_W'(DXW);
                    r_below      <= c_prev_ok && c_below;
                    r_prev_x     <= r_x;
                    r_prev_y     <= r_y;
                    r_prev_valid <= 1'b1;
                    if (c_cross) begin
                        r_state <= S_DIV;
                    end else if (c_kept) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_rem <= c_rem_nx[31:0];
                    r_quo <= (r_quo << 1) + DXW'(c_digit);
                    r_dx  <= r_dx << 1;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (c_out_free) begin
                        if (r_cross) begin
                            r_out_x     <= c_cross_x[OUT_X_W-1:0];
                            r_out_y     <= r_lvl;
                            r_out_cross <= 1'b1;
                            r_out_last  <= !r_kept;
                            r_state     <= r_kept ? S_EMIT2 : S_IDLE;
                        end else begin
                            r_out_x     <= c_kept_x[OUT_X_W-1:0];
                            r_out_y     <= {{2{r_y[15]}}, r_y};
                            r_out_cross <= 1'b0;
                            r_out_last  <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                S_EMIT2: begin
                    if (c_out_free) begin
                        r_out_x     <= c_kept_x[OUT_X_W-1:0];
                        r_out_y     <= {{2{r_y[15]}}, r_y};
                        r_out_cross <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.out_x        = r_out_x;
    assign o_out.out_y        = r_out_y;
    assign o_out.is_crossing  = r_out_cross;
    assign o_out.last_of_item = r_out_last;

    `ASSERT_CLK(a_kept_is_last, i_clk, i_rst_n, (o_out.valid && !o_out.is_crossing) |-> o_out.last_of_item, "kept sample not marked last of its item")
    `ASSERT_CLK(a_rem_below_den, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_rem < r_den), "divider remainder reached the divisor")
    `ASSERT_NEVER(a_orphan_crossing, i_clk, i_rst_n, o_out.valid && o_out.is_crossing && !o_out.last_of_item && (r_state != S_EMIT2), "crossing waits for a kept sample that is not pending")

endmodule

`default_nettype wire

/* verif/below_threshold_clip_with_crossings_top_tb.sv */
`timescale 1ns / 1ps

module below_threshold_clip_with_crossings_top_tb;
    import btc_pkg::*;

    localparam int XF           = X_FRAC_BITS_DEF;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [OUT_X_W-1:0] out_x;
        logic [OUT_Y_W-1:0] out_y;
        logic               is_crossing;
        logic               last_of_item;
    } t_clip_point;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    btc_in_if  in_ch ();
    btc_out_if out_ch ();

    below_threshold_clip_with_crossings_top #(
        .X_FRAC_BITS (XF)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the level registers
    logic signed [15:0] cur_y_min;
    logic        [15:0] cur_y_range;
    logic        [16:0] cur_fraction;

    // shadow of the previous-sample state
    logic        [31:0] prev_sx;
    logic signed [15:0] prev_sy;
    bit                 prev_seen;
    bit                 below_flag;

    t_clip_point expected_points[$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_request = 1'b0;

    function automatic void predict_clip_points(logic [31:0] x, logic signed [15:0] y,
                                                logic start);
        longint      p, num, den, lvl;
        logic [127:0] prod, off;
        logic [31:0] dxi;
        logic [39:0] dx, cx;
        t_clip_point pts[2];
        int          n;
        bit          below;
        n = 0;
        if (start) begin
            prev_seen  = 1'b0;
            below_flag = 1'b0;
        end
        if (prev_seen) begin
            p     = longint'(cur_fraction) * longint'(cur_y_range);
            below = ((longint'(y) - longint'(cur_y_min)) * 65536) < p;
            if (below != below_flag && y != prev_sy && x > prev_sx) begin
                num = longint'(cur_y_min) * 65536 + p - longint'(prev_sy) * 65536;
                den = (longint'(y) - longint'(prev_sy)) * 65536;
                if (den < 0) begin
                    den = -den;
                    num = -num;
                end
                // crossing kept only when it lies on the segment
                if (num >= 0 && num <= den) begin
                    dxi  = x - prev_sx;
                    dx   = {8'd0, dxi} << XF;
                    prod = num;
                    prod = prod * dx;
                    off  = prod / den;
                    cx   = ({8'd0, prev_sx} << XF) + off[39:0];
                    lvl  = longint'(cur_y_min) + (p >>> 16);
                    pts[n] = '{out_x: cx, out_y: lvl[17:0], is_crossing: 1'b1,
                               last_of_item: 1'b0};
                    n++;
                end
            end
            if (below) begin
                pts[n] = '{out_x: {8'd0, x} << XF, out_y: {{2{y[15]}}, y},
                           is_crossing: 1'b0, last_of_item: 1'b0};
                n++;
            end
            below_flag = below;
        end else begin
            below_flag = 1'b0;
        end
        prev_sx   = x;
        prev_sy   = y;
        prev_seen = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) pts[i].last_of_item = 1'b1;
            expected_points.push_back(pts[i]);
        end
    endfunction

    function automatic logic signed [15:0] y_near_level(int spread);
        longint lvl, v;
        lvl = longint'(cur_y_min) + ((longint'(cur_fraction) * longint'(cur_y_range)) >>> 16);
        v   = lvl + longint'($urandom_range(2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_Y_MIN:    cur_y_min    = data[15:0];
            CFG_Y_RANGE:  cur_y_range  = data[15:0];
            CFG_FRACTION: cur_fraction = data;
            default: ;
        endcase
    endtask

    task automatic send_sample(logic [31:0] x, logic signed [15:0] y, logic start);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.sample_x     = x;
        in_ch.sample_y     = y;
        in_ch.start_series = start;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_clip_points(x, y, start);
    endtask

    // drop valid, wait for every result, then let an item that yields no result leave the sequencer
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic signed [15:0] ymin, logic [15:0] yrange,
                              logic [16:0] frac);
        settle();
        write_reg(CFG_Y_MIN, {1'b0, ymin});
        write_reg(CFG_Y_RANGE, {1'b0, yrange});
        write_reg(CFG_FRACTION, frac);
    endtask

    task automatic send_series(int len, int spread, int unsigned max_step, bit broken);
        logic [31:0]        x;
        logic signed [15:0] y;
        x = $urandom;
        y = 16'sd0;
        for (int i = 0; i < len; i++) begin
            if (i > 0) begin
                if (broken && $urandom_range(3) == 0) x = x - $urandom_range(1);
                else x = x + $urandom_range(max_step, 1);
            end
            // broken series repeat y now and then for flat segments
            if (!(i > 0 && broken && $urandom_range(3) == 0)) y = y_near_level(spread);
            send_sample(x, y, i == 0);
        end
    endtask

    task automatic test_directed_edges();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // reset values of the level registers
        cur_y_min    = Y_MIN_RST;
        cur_y_range  = Y_RANGE_RST;
        cur_fraction = FRACTION_RST;
        send_sample(32'd0, -16'sd32768, 1'b1);
        send_sample(32'd1, -16'sd32768, 1'b0);
        send_sample(32'd10, 16'sd32767, 1'b0);
        send_sample(32'd10, -16'sd100, 1'b0);
        send_sample(32'd20, -16'sd50, 1'b0);
        send_sample(32'hFFFF_FFFF, 16'sd32767, 1'b0);
        send_sample(32'hFFFF_FFFF, 16'sd6553, 1'b0);
        send_sample(32'hFFFF_FFFF, 16'sd0, 1'b1);
        send_sample(32'h8000_0000, 16'sd6554, 1'b1);
        send_sample(32'h8000_0001, 16'sd6553, 1'b0);
        send_sample(32'h8000_0002, 16'sd6554, 1'b0);
        send_sample(32'd100, 16'sd200, 1'b1);
        send_sample(32'd101, 16'sd300, 1'b0);
        send_sample(32'h5555_5555, 16'sh5555, 1'b1);
        send_sample(32'hAAAA_AAAA, 16'shAAAA, 1'b0);
    endtask

    task automatic test_zero_range_bounds();
        // level is y_min alone in the first two settings; crossings land on both ends of the segment
        set_config(16'sd100, 16'd0, 17'd65536);
        send_sample(32'd0, 16'sd100, 1'b1);
        send_sample(32'd4, 16'sd99, 1'b0);
        send_sample(32'd8, 16'sd100, 1'b0);
        set_config(-16'sd32768, 16'd0, 17'd131071);
        send_sample(32'd5, -16'sd32768, 1'b1);
        send_sample(32'd6, -16'sd32768, 1'b0);
        send_sample(32'd7, 16'sd32767, 1'b0);
        set_config(16'sd0, 16'd65535, 17'd131071);
        send_sample(32'd1000, 16'sd32767, 1'b1);
        send_sample(32'd2000, -16'sd32768, 1'b0);
        send_sample(32'd3000, 16'sd32767, 1'b0);
    endtask

    task automatic random_items(int n_items);
        int          sent, r, len, spread;
        int unsigned max_step;
        sent = 0;
        while (sent < n_items) begin
            r   = $urandom_range(99);
            len = $urandom_range(12, 2);
            case ($urandom_range(2))
                0: spread = 4;
                1: spread = 400;
                default: spread = 40000;
            endcase
            case ($urandom_range(3))
                0: max_step = 4;
                1: max_step = 5000;
                2: max_step = 32'h0100_0000;
                default: max_step = 32'hFFFF_FFFF;
            endcase
            if (r < 90) begin
                send_series(len, spread, max_step, r >= 78);
                sent += len;
            end else begin
                send_sample($urandom, 16'($urandom), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    task automatic test_random_under_idle(int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        set_config(16'sd0, 16'd65535, 17'd6554);
        random_items(60);
        set_config(-16'sd32768, 16'd65535, 17'd65536);
        random_items(60);
        set_config(16'sd32767, 16'd65535, 17'd131071);
        random_items(60);
        set_config(-16'sd32768, 16'd0, 17'd0);
        random_items(60);
        set_config(16'($urandom), 16'($urandom), 17'($urandom_range(131071)));
        random_items(60);
        set_config(16'($urandom), 16'($urandom), 17'($urandom_range(65536)));
        random_items(60);
    endtask

    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(16'sd0, 16'd1000, 17'd32768);
        hold_request = 1'b1;
        send_series(40, 4, 8, 1'b0);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_clip_point want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected result: out_x %h out_y %h", out_ch.out_x, out_ch.out_y);
                fail_count++;
            end else begin
                want = expected_points.pop_front();
                if (out_ch.out_x !== want.out_x) begin
                    $error("out_x: expected %h, got %h", want.out_x, out_ch.out_x);
                    fail_count++;
                end
                if (out_ch.out_y !== want.out_y) begin
                    $error("out_y: expected %h, got %h", want.out_y, out_ch.out_y);
                    fail_count++;
                end
                if (out_ch.is_crossing !== want.is_crossing) begin
                    $error("is_crossing: expected %b, got %b", want.is_crossing,
                           out_ch.is_crossing);
                    fail_count++;
                end
                if (out_ch.last_of_item !== want.last_of_item) begin
                    $error("last_of_item: expected %b, got %b", want.last_of_item,
                           out_ch.last_of_item);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("below_threshold_clip_with_crossings_top_tb failed");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_Y_MIN;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.sample_x     = '0;
        in_ch.sample_y     = '0;
        in_ch.start_series = 1'b0;
        prev_sx            = '0;
        prev_sy            = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_edges();
        test_zero_range_bounds();
        test_random_under_idle(34, 77);
        test_random_under_idle(77, 34);
        test_random_under_idle(0, 0);
        test_output_hold_off();
        settle();
        if (fail_count == 0)
            $display("below_threshold_clip_with_crossings_top_tb passed");
        else
            $display("below_threshold_clip_with_crossings_top_tb failed");
        $finish;
    end

endmodule
